// ----- sv/cuc_pkg.sv -----
// cuc_pkg: shared constants and codes for the CUC time code decoder.
// No dependencies; imported by the decoder top level.
package cuc_pkg;

  localparam int MAX_COARSE_OCTETS = 4;
  localparam int MAX_FINE_OCTETS   = 3;

  localparam int CODE_W   = 8;
  localparam int COARSE_W = 32;
  localparam int FINE_W   = 24;
  localparam int OCT_W    = 3;
  localparam int COUNT_W  = 4;
  localparam int INDEX_W  = 2;
  localparam int DATA_W   = 3;

  localparam logic [CODE_W-1:0] EPOCH_ID_TAI    = 8'h10;
  localparam logic [CODE_W-1:0] EPOCH_ID_AGENCY = 8'h20;

  typedef enum logic [1:0] {
    STATUS_OK           = 2'd0,
    STATUS_BAD_CONFIG   = 2'd1,
    STATUS_BAD_LENGTH   = 2'd2,
    STATUS_BAD_PREAMBLE = 2'd3
  } status_t;

  typedef enum logic [INDEX_W-1:0] {
    REG_AGENCY_EPOCH      = 2'd0,
    REG_EXPLICIT_PREAMBLE = 2'd1,
    REG_COARSE_OCTETS     = 2'd2,
    REG_FINE_OCTETS       = 2'd3
  } reg_index_t;

endpackage

// ----- sv/cuc_if.sv -----
// cuc_in_if / cuc_out_if: valid-ready channels of the CUC time code decoder.
// Depends on cuc_pkg for field widths.
interface cuc_in_if import cuc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] code_byte;
  logic              final_byte;

  modport source (output valid, output code_byte, output final_byte, input ready);
  modport sink   (input valid, input code_byte, input final_byte, output ready);
endinterface

interface cuc_out_if import cuc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [COARSE_W-1:0] coarse_time;
  logic [FINE_W-1:0]   fine_time;
  logic [1:0]          status;

  modport source (output valid, output coarse_time, output fine_time, output status,
                  input ready);
  modport sink   (input valid, input coarse_time, input fine_time, input status,
                  output ready);
endinterface

// ----- sv/cuc_time_code_decoder.sv -----
// cuc_time_code_decoder: CCSDS unsegmented time code (basic) decoder.
// Depends on cuc_pkg and the channel interfaces in cuc_if.sv.
//
// Usage
// - in_word carries one byte of a time code per word, final_byte set on the
//   last byte. With an explicit preamble the first byte is the P-field; the
//   following bytes shift big-endian into coarse and then fine time.
// - out_word carries one word per time code, on its final byte: coarse time,
//   fine time and a status (invalid configuration, wrong length, preamble
//   mismatch, checked in that order). On any error both times read zero.
// - cfg_wr_en/cfg_index/cfg_data write the four layout registers; write them
//   only while no time code is in flight and no result is pending.
// Timing
// - One byte per cycle, less while the receiver stalls. A result appears in
//   the output register in the cycle after its final byte is accepted; the
//   byte state, accumulators and result register are each a single register stage.
// - When the receiver stalls with a result held, in_word.ready drops until the
//   result is taken (or is taken in the same cycle), so no word is lost.
// Reset
// - rst (synchronous) clears the byte counter, accumulators and result valid,
//   and loads the registers with TAI epoch, explicit preamble, four coarse and
//   no fine octets.
module cuc_time_code_decoder import cuc_pkg::*; #(
  parameter int MAX_COARSE = MAX_COARSE_OCTETS,
  parameter int MAX_FINE   = MAX_FINE_OCTETS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [INDEX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]  cfg_data,
  cuc_in_if.sink             in_word,
  cuc_out_if.source          out_word
);

  // layout registers
  logic             agency_epoch;
  logic             explicit_preamble;
  logic [OCT_W-1:0] coarse_octets;
  logic [OCT_W-1:0] fine_octets;

  // per-code state
  logic [COUNT_W-1:0]  byte_count;
  logic [COARSE_W-1:0] coarse_acc;
  logic [FINE_W-1:0]   fine_acc;
  logic                preamble_bad;

  logic [COUNT_W-1:0]  byte_count_next;
  logic [COARSE_W-1:0] coarse_acc_next;
  logic [FINE_W-1:0]   fine_acc_next;
  logic                preamble_bad_next;

  // result register
  logic                res_valid;
  logic [COARSE_W-1:0] res_coarse;
  logic [FINE_W-1:0]   res_fine;
  status_t             res_status;
  status_t             status_next;

  logic               accept;
  logic [COUNT_W-1:0] coarse_end;
  logic [COUNT_W-1:0] fine_end;
  logic [1:0]         coarse_m1;
  logic [CODE_W-1:0]  preamble;
  logic               config_ok;

  // Take a new byte whenever the result register is empty or being emptied.
  assign in_word.ready = !res_valid || out_word.ready;
  assign accept        = in_word.valid && in_word.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      agency_epoch      <= 1'b0;
      explicit_preamble <= 1'b1;
      coarse_octets     <= OCT_W'(4);
      fine_octets       <= '0;
    end else if (cfg_wr_en) begin
      case (reg_index_t'(cfg_index))
        REG_AGENCY_EPOCH:      agency_epoch      <= cfg_data[0];
        REG_EXPLICIT_PREAMBLE: explicit_preamble <= cfg_data[0];
        REG_COARSE_OCTETS:     coarse_octets     <= cfg_data;
        REG_FINE_OCTETS:       fine_octets       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Field boundaries in byte positions; all fit in the 4-bit counter range.
  assign coarse_end = COUNT_W'(explicit_preamble) + COUNT_W'(coarse_octets);
  assign fine_end   = coarse_end + COUNT_W'(fine_octets);
  assign coarse_m1  = coarse_octets[1:0] - 2'd1;
  assign preamble   = (agency_epoch ? EPOCH_ID_AGENCY : EPOCH_ID_TAI)
                    | {4'b0000, coarse_m1, fine_octets[1:0]};
  assign config_ok  = (coarse_octets != '0)
                   && (coarse_octets <= OCT_W'(MAX_COARSE))
                   && (fine_octets <= OCT_W'(MAX_FINE));

  // Place the byte: preamble check, coarse shift, fine shift, or drop it.
  always_comb begin
    coarse_acc_next   = coarse_acc;
    fine_acc_next     = fine_acc;
    preamble_bad_next = preamble_bad;
    if (explicit_preamble && byte_count == '0) begin
      preamble_bad_next = (in_word.code_byte != preamble);
    end else if (byte_count >= COUNT_W'(explicit_preamble) && byte_count < coarse_end) begin
      coarse_acc_next = {coarse_acc[COARSE_W-CODE_W-1:0], in_word.code_byte};
    end else if (byte_count >= coarse_end && byte_count < fine_end) begin
      fine_acc_next = {fine_acc[FINE_W-CODE_W-1:0], in_word.code_byte};
    end
    // saturate the counter
    byte_count_next = (byte_count == '1) ? byte_count : byte_count + COUNT_W'(1);
  end

  always_comb begin
    if (!config_ok) begin
      status_next = STATUS_BAD_CONFIG;
    end else if (byte_count_next != fine_end) begin
      status_next = STATUS_BAD_LENGTH;
    end else if (explicit_preamble && preamble_bad_next) begin
      status_next = STATUS_BAD_PREAMBLE;
    end else begin
      status_next = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count   <= '0;
      coarse_acc   <= '0;
      fine_acc     <= '0;
      preamble_bad <= 1'b0;
    end else if (accept) begin
      if (in_word.final_byte) begin
        // clear for the next time code
        byte_count   <= '0;
        coarse_acc   <= '0;
        fine_acc     <= '0;
        preamble_bad <= 1'b0;
      end else begin
        byte_count   <= byte_count_next;
        coarse_acc   <= coarse_acc_next;
        fine_acc     <= fine_acc_next;
        preamble_bad <= preamble_bad_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept && in_word.final_byte) begin
      res_valid <= 1'b1;
    end else if (out_word.ready) begin
      res_valid <= 1'b0;
    end
  end

  // Load the result; zero both times on any error.
  always_ff @(posedge clk) begin
    if (accept && in_word.final_byte) begin
      res_status <= status_next;
      res_coarse <= (status_next == STATUS_OK) ? coarse_acc_next : '0;
      res_fine   <= (status_next == STATUS_OK) ? fine_acc_next : '0;
    end
  end

  assign out_word.valid       = res_valid;
  assign out_word.coarse_time = res_coarse;
  assign out_word.fine_time   = res_fine;
  assign out_word.status      = res_status;

endmodule

// ----- bench/cuc_time_code_decoder_tb.sv -----
// cuc_time_code_decoder_tb: self-checking bench for the CUC time code decoder.
// Depends on cuc_pkg, the channel interfaces in cuc_if.sv and the decoder itself.
// Feeds byte streams under many layouts and checks every decoded time word.
module cuc_time_code_decoder_tb import cuc_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 500000;
  localparam int LONG_HOLD   = 300;
  // Let a byte still in flight settle before touching the layout registers.
  localparam int SETTLE      = 4;

  typedef struct {
    logic [CODE_W-1:0] code;
    logic              last;
  } code_item_t;

  typedef struct {
    logic [COARSE_W-1:0] coarse;
    logic [FINE_W-1:0]   fine;
    status_t             status;
  } time_result_t;

  typedef struct {
    logic             epoch;
    logic             explicit_p;
    logic [OCT_W-1:0] coarse;
    logic [OCT_W-1:0] fine;
  } layout_t;

  typedef enum int {
    SHAPE_GOOD,
    SHAPE_BAD_PREAMBLE,
    SHAPE_SHORT,
    SHAPE_LONG,
    SHAPE_NOISE
  } code_shape_t;

  // Clock, reset and every block input start at known values.
  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               cfg_wr_en   = 1'b0;
  logic [INDEX_W-1:0] cfg_index   = '0;
  logic [DATA_W-1:0]  cfg_data    = '0;
  logic               src_valid   = 1'b0;
  logic [CODE_W-1:0]  src_code    = '0;
  logic               src_last    = 1'b0;
  logic               sink_ready  = 1'b0;

  cuc_in_if  in_if ();
  cuc_out_if out_if ();

  assign in_if.valid      = src_valid;
  assign in_if.code_byte  = src_code;
  assign in_if.final_byte = src_last;
  assign out_if.ready     = sink_ready;

  cuc_time_code_decoder i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_word   (in_if),
    .out_word  (out_if)
  );

  initial forever #2 clk = ~clk;

  // Bytes waiting to be offered, and decoded words still owed by the block.
  code_item_t   byte_queue[$];
  time_result_t pending_times[$];
  code_item_t   next_item;

  int failures    = 0;
  int total_items = 0;
  int cycle_count = 0;

  // Idle odds in percent per word slot; zero gives back-to-back traffic.
  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  int src_gap_left  = 0;
  int sink_gap_left = 0;
  int hold_left     = 0;
  int hold_ticket   = 0;
  int hold_served   = 0;

  // Shadow of the layout registers, reset values first.
  logic             lay_epoch    = 1'b0;
  logic             lay_explicit = 1'b1;
  logic [OCT_W-1:0] lay_coarse   = 3'd4;
  logic [OCT_W-1:0] lay_fine     = 3'd0;

  // Shadow of the decoding state.
  logic [COUNT_W-1:0]  byte_cnt   = '0;
  logic [COARSE_W-1:0] coarse_acc = '0;
  logic [FINE_W-1:0]   fine_acc   = '0;
  logic                pre_bad    = 1'b0;

  function automatic logic layout_valid();
    return lay_coarse >= 1 && lay_coarse <= MAX_COARSE_OCTETS &&
           lay_fine <= MAX_FINE_OCTETS;
  endfunction

  // P-field: epoch ID, coarse count less one in bits 3:2, fine count in 1:0.
  function automatic logic [CODE_W-1:0] expected_p_field();
    logic [OCT_W-1:0] c_less;
    c_less = lay_coarse - 3'd1;
    return (lay_epoch ? EPOCH_ID_AGENCY : EPOCH_ID_TAI) |
           {4'd0, c_less[1:0], 2'd0} | {6'd0, lay_fine[1:0]};
  endfunction

  function automatic int layout_length();
    return (lay_explicit ? 1 : 0) + int'(lay_coarse) + int'(lay_fine);
  endfunction

  // Advance the shadow decoder by one accepted byte; owe a word on the last one.
  task automatic decode_byte(input logic [CODE_W-1:0] b, input logic last);
    int           pos;
    int           off;
    int           c_end;
    int           f_end;
    time_result_t res;
    pos   = int'(byte_cnt);
    off   = lay_explicit ? 1 : 0;
    c_end = off + int'(lay_coarse);
    f_end = c_end + int'(lay_fine);
    if (off == 1 && pos == 0) begin
      pre_bad = (b != expected_p_field());
    end else if (pos >= off && pos < c_end) begin
      coarse_acc = {coarse_acc[COARSE_W-9:0], b};
    end else if (pos >= c_end && pos < f_end) begin
      fine_acc = {fine_acc[FINE_W-9:0], b};
    end
    // Hold the counter at its ceiling rather than wrap.
    if (byte_cnt != '1) byte_cnt++;
    if (last) begin
      if (!layout_valid()) res.status = STATUS_BAD_CONFIG;
      else if (int'(byte_cnt) != f_end) res.status = STATUS_BAD_LENGTH;
      else if (off == 1 && pre_bad) res.status = STATUS_BAD_PREAMBLE;
      else res.status = STATUS_OK;
      // Any error zeroes both times.
      res.coarse = (res.status == STATUS_OK) ? coarse_acc : '0;
      res.fine   = (res.status == STATUS_OK) ? fine_acc : '0;
      pending_times = {pending_times, res};
      byte_cnt   = '0;
      coarse_acc = '0;
      fine_acc   = '0;
      pre_bad    = 1'b0;
    end
  endtask

  task automatic push_byte(input logic [CODE_W-1:0] b, input logic last);
    code_item_t it;
    it.code = b;
    it.last = last;
    byte_queue = {byte_queue, it};
    total_items++;
  endtask

  // Queue one time code of len bytes; fill < 0 gives random content.
  task automatic push_code(input int len, input logic bad_pre, input int fill);
    logic [CODE_W-1:0] b;
    for (int i = 0; i < len; i++) begin
      if (i == 0 && lay_explicit) begin
        b = expected_p_field();
        if (bad_pre) b = b ^ CODE_W'($urandom_range(1, 255));
      end else if (fill < 0) begin
        b = CODE_W'($urandom_range(0, 255));
      end else begin
        b = CODE_W'(fill);
      end
      push_byte(b, i == len - 1);
    end
  endtask

  // Mostly well-formed codes with random content, the rest broken or noise.
  task automatic add_random_codes(input int n);
    int          target;
    int          len;
    int          r;
    code_shape_t shape;
    target = total_items + n;
    while (total_items < target) begin
      len = layout_length();
      r   = $urandom_range(1, 100);
      if (r <= 64) shape = SHAPE_GOOD;
      else if (r <= 72) shape = SHAPE_BAD_PREAMBLE;
      else if (r <= 80) shape = SHAPE_SHORT;
      else if (r <= 88) shape = SHAPE_LONG;
      else shape = SHAPE_NOISE;
      case (shape)
        SHAPE_GOOD: begin
          push_code(len > 0 ? len : 1, 1'b0, -1);
        end
        SHAPE_BAD_PREAMBLE: begin
          push_code(len > 0 ? len : 1, lay_explicit, -1);
        end
        SHAPE_SHORT: begin
          push_code(len > 1 ? $urandom_range(1, len - 1) : len + 1, 1'b0, -1);
        end
        SHAPE_LONG: begin
          // Now and then run far enough to pin the byte counter.
          if ($urandom_range(0, 3) == 0) push_code($urandom_range(15, 20), 1'b0, -1);
          else push_code(len + $urandom_range(1, 3), 1'b0, -1);
        end
        default: begin
          // Loose bytes; a partial code may carry over into the next layout.
          for (int i = $urandom_range(1, 6); i > 0; i--) begin
            push_byte(CODE_W'($urandom_range(0, 255)), $urandom_range(0, 2) == 0);
          end
        end
      endcase
    end
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [DATA_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_AGENCY_EPOCH:      lay_epoch    <= val[0];
      REG_EXPLICIT_PREAMBLE: lay_explicit <= val[0];
      REG_COARSE_OCTETS:     lay_coarse   <= val;
      default:               lay_fine     <= val;
    endcase
  endtask

  task automatic apply_layout(input layout_t l);
    write_reg(REG_AGENCY_EPOCH, {2'd0, l.epoch});
    write_reg(REG_EXPLICIT_PREAMBLE, {2'd0, l.explicit_p});
    write_reg(REG_COARSE_OCTETS, l.coarse);
    write_reg(REG_FINE_OCTETS, l.fine);
    @(posedge clk);
  endtask

  // Wait until every byte is taken and every word has come back.
  task automatic drain();
    while (byte_queue.size() != 0 || src_valid || pending_times.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic int pick_idle_pct();
    int r;
    r = $urandom_range(0, 3);
    return (r == 0) ? 0 : (r == 1) ? 5 : (r == 2) ? 15 : 30;
  endfunction

  function automatic layout_t random_layout(input logic force_valid);
    layout_t l;
    l.epoch      = 1'($urandom_range(0, 1));
    l.explicit_p = 1'($urandom_range(0, 1));
    if (force_valid || $urandom_range(0, 4) != 0) begin
      l.coarse = OCT_W'($urandom_range(1, MAX_COARSE_OCTETS));
      l.fine   = OCT_W'($urandom_range(0, MAX_FINE_OCTETS));
    end else if ($urandom_range(0, 1) == 0) begin
      // Coarse count of zero or above the maximum.
      l.coarse = ($urandom_range(0, 3) == 0) ? 3'd0 : OCT_W'($urandom_range(5, 7));
      l.fine   = OCT_W'($urandom_range(0, 7));
    end else begin
      l.coarse = OCT_W'($urandom_range(1, 4));
      l.fine   = OCT_W'($urandom_range(4, 7));
    end
    return l;
  endfunction

  // Sender: offer the next queued byte, with random gaps between words.
  always @(posedge clk) begin
    if (rst) begin
      src_valid    <= 1'b0;
      src_gap_left <= 0;
    end else if (!src_valid || in_if.ready) begin
      if (src_gap_left > 0) begin
        src_gap_left <= src_gap_left - 1;
        src_valid    <= 1'b0;
      end else if (byte_queue.size() != 0 && $urandom_range(1, 100) <= src_idle_pct) begin
        // Open a gap of random length, this cycle included.
        src_gap_left <= $urandom_range(0, 16);
        src_valid    <= 1'b0;
      end else if (byte_queue.size() != 0) begin
        next_item  = byte_queue.pop_front();
        src_valid <= 1'b1;
        src_code  <= next_item.code;
        src_last  <= next_item.last;
      end else begin
        src_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request so the block backs up.
  always @(posedge clk) begin
    if (rst) begin
      sink_ready    <= 1'b0;
      sink_gap_left <= 0;
      hold_left     <= 0;
    end else if (hold_served != hold_ticket) begin
      hold_served <= hold_ticket;
      hold_left   <= LONG_HOLD;
      sink_ready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      sink_ready <= 1'b0;
    end else if (sink_gap_left > 0) begin
      sink_gap_left <= sink_gap_left - 1;
      sink_ready    <= 1'b0;
    end else if ($urandom_range(1, 100) <= sink_idle_pct) begin
      sink_gap_left <= $urandom_range(0, 16);
      sink_ready    <= 1'b0;
    end else begin
      sink_ready <= 1'b1;
    end
  end

  // Track every accepted input word in the shadow decoder.
  always @(posedge clk) begin
    if (!rst && in_if.valid && in_if.ready) decode_byte(in_if.code_byte, in_if.final_byte);
  end

  // Compare every accepted output word with the oldest owed result.
  always @(posedge clk) begin
    time_result_t want;
    if (!rst && out_if.valid && out_if.ready) begin
      if (pending_times.size() == 0) begin
        $error("unexpected time word: coarse_time %h fine_time %h status %0d",
               out_if.coarse_time, out_if.fine_time, out_if.status);
        failures++;
      end else begin
        want = pending_times.pop_front();
        if (out_if.coarse_time !== want.coarse) begin
          $error("coarse_time: expected %h, actual %h", want.coarse, out_if.coarse_time);
          failures++;
        end
        if (out_if.fine_time !== want.fine) begin
          $error("fine_time: expected %h, actual %h", want.fine, out_if.fine_time);
          failures++;
        end
        if (out_if.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_if.status);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Watchdog: give up if the run hangs.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // Stimulus: directed codes under the reset layout, then phases of random codes.
  initial begin
    layout_t fixed_layouts[7];
    fixed_layouts = '{
      '{1'b0, 1'b1, 3'd1, 3'd0},   // smallest layout with P-field
      '{1'b1, 1'b1, 3'd4, 3'd3},   // largest layout, agency epoch
      '{1'b1, 1'b0, 3'd4, 3'd3},
      '{1'b0, 1'b0, 3'd1, 3'd0},   // single-byte code
      '{1'b1, 1'b1, 3'd0, 3'd3},   // invalid: no coarse octets
      '{1'b0, 1'b1, 3'd7, 3'd7},   // invalid: both counts at the top
      '{1'b1, 1'b0, 3'd2, 3'd4}    // invalid fine count
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    repeat (3) @(posedge clk);

    // Reset layout: P-field plus four coarse octets.
    src_idle_pct  = 10;
    sink_idle_pct = 10;
    push_code(5, 1'b0, 8'h00);      // all-zero time
    push_code(5, 1'b0, 8'hFF);      // all-ones time
    push_code(5, 1'b1, -1);         // P-field mismatch
    push_code(1, 1'b0, -1);         // final flag on the P-field itself
    push_code(6, 1'b0, -1);         // one byte too many
    drain();

    foreach (fixed_layouts[i]) begin
      apply_layout(fixed_layouts[i]);
      src_idle_pct  = pick_idle_pct();
      sink_idle_pct = pick_idle_pct();
      // Stall the receiver at length while the sender keeps offering bytes.
      if (i == 1) hold_ticket++;
      add_random_codes(90);
      drain();
    end

    while (total_items < 1150) begin
      apply_layout(random_layout(1'b0));
      src_idle_pct  = pick_idle_pct();
      sink_idle_pct = pick_idle_pct();
      add_random_codes($urandom_range(60, 120));
      drain();
    end

    // Closing stretch at full rate on both sides.
    apply_layout(random_layout(1'b1));
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    add_random_codes(150);
    drain();

    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/cuc_pkg.sv
sv/cuc_if.sv
sv/cuc_time_code_decoder.sv
bench/cuc_time_code_decoder_tb.sv
